FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the display driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: design/dldd_pkg.sv
// Shared constants, types and functions of the decimal digit LED display driver.
`timescale 1ns / 1ps
`default_nettype none

package dldd_pkg;

    localparam int MAX_DIGITS_DEF = 6;
    localparam int LEDS_PER_DIGIT = 9;

    localparam int NUM_W = 20;
    localparam int COL_W = 24;
    localparam int DIG_W = 4;
    localparam int CNT_W = 3;
    localparam int PIX_W = 6;
    localparam int SH_W  = 4;

    localparam logic [COL_W-1:0] WHITE_RGB = 24'hFFFFFF;
    localparam logic [COL_W-1:0] BLACK_RGB = 24'h000000;
    localparam logic [DIG_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [NUM_W-1:0] NUMBER_MAX = 20'd999999;

    // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT for every 20-bit x.
    localparam logic [NUM_W-1:0] DIV10_MAGIC = 20'd838861;
    localparam int DIV10_SHIFT = 23;

    // Command codes.
    typedef enum logic [2:0] {
        REQ_SET_NUMBER = 3'd0,
        REQ_SET_DIGIT  = 3'd1,
        REQ_INCREMENT  = 3'd2,
        REQ_DECREMENT  = 3'd3,
        REQ_SHIFT      = 3'd4,
        REQ_SET_COLOUR = 3'd5,
        REQ_RENDER     = 3'd6
    } t_req;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SPLIT,
        ST_SUM_READ,
        ST_SUM_ADD,
        ST_SHIFT_READ,
        ST_SHIFT_WRITE,
        ST_FILL,
        ST_STATUS,
        ST_FETCH,
        ST_PIXEL
    } t_state;

    // One result item.
    typedef struct packed {
        logic             is_pixel;
        logic [NUM_W-1:0] current_number;
        logic [PIX_W-1:0] pixel_index;
        logic [COL_W-1:0] pixel_colour;
        logic             error_flag;
        logic             last;
    } t_result;

    // Address width of a store with the given depth, at least one bit.
    function automatic int addr_w(input int depth);
        addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Powers of ten up to 10^6; larger indexes saturate.
    function automatic logic [NUM_W-1:0] pow_ten(input logic [CNT_W-1:0] idx);
        logic [NUM_W-1:0] p;
        unique case (idx)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            default: p = 20'd1000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: design/dldd_if.sv
// Request and result channel interfaces of the display driver.
`timescale 1ns / 1ps
`default_nettype none

interface dldd_req_if;
    import dldd_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       req_type;
    logic [NUM_W-1:0] value;
    logic [CNT_W-1:0] digit_index;
    logic [DIG_W-1:0] digit_value;
    logic signed [SH_W-1:0] shift_amount;
    logic [COL_W-1:0] colour;
    logic             colour_all;

    modport source (
        output valid, req_type, value, digit_index, digit_value, shift_amount,
               colour, colour_all,
        input  ready
    );
    modport sink (
        input  valid, req_type, value, digit_index, digit_value, shift_amount,
               colour, colour_all,
        output ready
    );
endinterface

interface dldd_res_if;
    import dldd_pkg::*;

    logic             valid;
    logic             ready;
    logic             is_pixel;
    logic [NUM_W-1:0] current_number;
    logic [PIX_W-1:0] pixel_index;
    logic [COL_W-1:0] pixel_colour;
    logic             error_flag;
    logic             last;

    modport source (
        output valid, is_pixel, current_number, pixel_index, pixel_colour,
               error_flag, last,
        input  ready
    );
    modport sink (
        input  valid, is_pixel, current_number, pixel_index, pixel_colour,
               error_flag, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/dldd_mem.sv
// Small synchronous store with one write port, one registered read port and reset values.
`timescale 1ns / 1ps
`default_nettype none

module dldd_mem #(
    parameter int               WIDTH       = 4,
    parameter int               DEPTH       = 6,
    parameter logic [WIDTH-1:0] RESET_VALUE = '0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [dldd_pkg::addr_w(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [dldd_pkg::addr_w(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    import dldd_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;

    // An entry that was never written since reset reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a read of the entry written at the same edge sees old data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : RESET_VALUE;
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/dldd_ctrl.sv
// Command sequencer: read-modify-write of the digit and colour stores, number and results.
`timescale 1ns / 1ps
`default_nettype none

module dldd_ctrl #(
    parameter int MAX_DIGITS = dldd_pkg::MAX_DIGITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [dldd_pkg::CNT_W-1:0]               i_cfg_wdata,
    dldd_req_if.sink                                 i_req,
    output logic                                     o_res_valid,
    output dldd_pkg::t_result                        o_res,
    input  logic                                     i_res_ready,
    output logic                                     o_dig_we,
    output logic [dldd_pkg::addr_w(MAX_DIGITS)-1:0]  o_dig_waddr,
    output logic [dldd_pkg::DIG_W-1:0]               o_dig_wdata,
    output logic [dldd_pkg::addr_w(MAX_DIGITS)-1:0]  o_dig_raddr,
    input  logic [dldd_pkg::DIG_W-1:0]               i_dig_rdata,
    output logic                                     o_col_we,
    output logic [dldd_pkg::addr_w(MAX_DIGITS)-1:0]  o_col_waddr,
    output logic [dldd_pkg::COL_W-1:0]               o_col_wdata,
    output logic [dldd_pkg::addr_w(MAX_DIGITS)-1:0]  o_col_raddr,
    input  logic [dldd_pkg::COL_W-1:0]               i_col_rdata
);
    import dldd_pkg::*;

    localparam int               AW       = addr_w(MAX_DIGITS);
    localparam logic [CNT_W-1:0] MAX_N    = CNT_W'(MAX_DIGITS);
    localparam logic [3:0]       LED_LAST = 4'(LEDS_PER_DIGIT - 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_cfg;
    logic [NUM_W-1:0] r_number, n_number;
    logic [NUM_W-1:0] r_acc, n_acc;
    logic [NUM_W-1:0] r_work, n_work;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_down, n_down;
    logic             r_err, n_err;
    logic             r_report, n_report;
    logic [3:0]       r_led, n_led;
    logic [PIX_W-1:0] r_pix, n_pix;

    // Captured request fields.
    logic [2:0]             r_req, n_req;
    logic [NUM_W-1:0]       r_value, n_value;
    logic [CNT_W-1:0]       r_di, n_di;
    logic [DIG_W-1:0]       r_dv, n_dv;
    logic signed [SH_W-1:0] r_sh, n_sh;
    logic [COL_W-1:0]       r_col, n_col;
    logic                   r_all, n_all;

    logic                   w_accept;
    logic [CNT_W-1:0]       w_n;
    logic [CNT_W-1:0]       w_last_ptr;
    logic                   w_at_last;
    logic [NUM_W-1:0]       w_maxn;
    logic [2*NUM_W-1:0]     w_prod;
    logic [NUM_W-DIV10_SHIFT+NUM_W-1:0] w_quot;
    logic [NUM_W-1:0]       w_tens;
    logic [DIG_W-1:0]       w_rem;
    logic [NUM_W-1:0]       w_term;
    logic signed [4:0]      w_src;
    logic                   w_src_ok;
    logic                   w_digit_bad;
    logic                   w_index_bad;
    logic                   w_shift_up;
    logic                   w_shift_done;
    logic                   w_lit;
    logic                   w_pixel_last;

    assign w_accept = i_req.valid && i_req.ready;

    // Digits in use, with out-of-range register values clamped.
    always_comb begin
        if (r_cfg == '0) begin
            w_n = CNT_W'(1);
        end else if (r_cfg > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = r_cfg;
        end
    end

    assign w_last_ptr = w_n - CNT_W'(1);
    assign w_at_last  = (r_ptr == w_last_ptr);
    assign w_maxn     = pow_ten(w_n) - NUM_W'(1);

    // One decimal digit per cycle: reciprocal multiply, then remainder.
    assign w_prod = r_work * DIV10_MAGIC;
    assign w_quot = w_prod[2*NUM_W-1:DIV10_SHIFT];
    assign w_tens = NUM_W'({w_quot, 3'b000}) + NUM_W'({w_quot, 1'b0});
    assign w_rem  = DIG_W'(r_work - w_tens);

    // Weighted digit for the number sum.
    assign w_term = NUM_W'(i_dig_rdata * pow_ten(r_ptr));

    // Source position of a shifted digit; outside the used digits it fills zero.
    assign w_src    = $signed({2'b00, r_ptr}) - $signed({r_sh[SH_W-1], r_sh});
    assign w_src_ok = !w_src[4] && (w_src[3:0] < {1'b0, w_n});

    assign w_digit_bad  = (r_dv > DIGIT_MAX) || (r_di >= w_n);
    assign w_index_bad  = (r_di >= w_n);
    assign w_shift_up   = !r_sh[SH_W-1] && (r_sh != '0);
    assign w_shift_done = r_down ? (r_ptr == '0) : w_at_last;

    // Pixel lighting: digit zero lights the whole pipe, otherwise one LED.
    assign w_lit        = (i_dig_rdata == '0) || (r_led == (i_dig_rdata - DIG_W'(1)));
    assign w_pixel_last = (r_led == LED_LAST) && w_at_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_state = ST_SUM_READ;
                end else if (w_accept) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (r_req)
                    REQ_SET_NUMBER,
                    REQ_INCREMENT,
                    REQ_DECREMENT:  n_state = ST_SPLIT;
                    REQ_SET_DIGIT:  n_state = w_digit_bad ? ST_STATUS : ST_SUM_READ;
                    REQ_SHIFT:      n_state = ST_SHIFT_READ;
                    REQ_SET_COLOUR: n_state = r_all ? ST_FILL : ST_STATUS;
                    REQ_RENDER:     n_state = ST_FETCH;
                    default:        n_state = ST_STATUS;
                endcase
            end
            ST_SPLIT: begin
                if (w_at_last) begin
                    n_state = ST_SUM_READ;
                end
            end
            ST_SUM_READ: begin
                n_state = ST_SUM_ADD;
            end
            ST_SUM_ADD: begin
                if (w_at_last) begin
                    n_state = r_report ? ST_STATUS : ST_IDLE;
                end else begin
                    n_state = ST_SUM_READ;
                end
            end
            ST_SHIFT_READ: begin
                n_state = ST_SHIFT_WRITE;
            end
            ST_SHIFT_WRITE: begin
                n_state = w_shift_done ? ST_SUM_READ : ST_SHIFT_READ;
            end
            ST_FILL: begin
                if (w_at_last) begin
                    n_state = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FETCH: begin
                n_state = ST_PIXEL;
            end
            ST_PIXEL: begin
                if (i_res_ready && (r_led == LED_LAST)) begin
                    n_state = w_at_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Store ports, handshake and result.
    always_comb begin
        i_req.ready = (r_state == ST_IDLE) && !i_cfg_we;

        o_dig_we    = 1'b0;
        o_dig_waddr = r_ptr[AW-1:0];
        o_dig_wdata = w_rem;
        o_dig_raddr = r_ptr[AW-1:0];
        o_col_we    = 1'b0;
        o_col_waddr = r_ptr[AW-1:0];
        o_col_wdata = r_col;
        o_col_raddr = r_ptr[AW-1:0];

        o_res_valid          = 1'b0;
        o_res.is_pixel       = 1'b0;
        o_res.current_number = r_number;
        o_res.pixel_index    = '0;
        o_res.pixel_colour   = BLACK_RGB;
        o_res.error_flag     = r_err;
        o_res.last           = 1'b1;

        unique case (r_state)
            ST_DISPATCH: begin
                if ((r_req == REQ_SET_DIGIT) && !w_digit_bad) begin
                    o_dig_we    = 1'b1;
                    o_dig_waddr = r_di[AW-1:0];
                    o_dig_wdata = r_dv;
                end
                if ((r_req == REQ_SET_COLOUR) && !r_all && !w_index_bad) begin
                    o_col_we    = 1'b1;
                    o_col_waddr = r_di[AW-1:0];
                end
            end
            ST_SPLIT: begin
                o_dig_we = 1'b1;
            end
            ST_SHIFT_READ: begin
                o_dig_raddr = w_src_ok ? w_src[AW-1:0] : '0;
            end
            ST_SHIFT_WRITE: begin
                o_dig_we    = 1'b1;
                o_dig_wdata = w_src_ok ? i_dig_rdata : '0;
            end
            ST_FILL: begin
                o_col_we = 1'b1;
            end
            ST_STATUS: begin
                o_res_valid = 1'b1;
            end
            ST_PIXEL: begin
                o_res_valid        = 1'b1;
                o_res.is_pixel     = 1'b1;
                o_res.pixel_index  = r_pix;
                o_res.pixel_colour = w_lit ? i_col_rdata : BLACK_RGB;
                o_res.error_flag   = 1'b0;
                o_res.last         = w_pixel_last;
            end
            ST_IDLE, ST_SUM_READ, ST_SUM_ADD, ST_FETCH: begin
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_number = r_number;
        n_acc    = r_acc;
        n_work   = r_work;
        n_ptr    = r_ptr;
        n_down   = r_down;
        n_err    = r_err;
        n_report = r_report;
        n_led    = r_led;
        n_pix    = r_pix;
        n_req    = r_req;
        n_value  = r_value;
        n_di     = r_di;
        n_dv     = r_dv;
        n_sh     = r_sh;
        n_col    = r_col;
        n_all    = r_all;

        unique case (r_state)
            ST_IDLE: begin
                n_ptr = '0;
                n_acc = '0;
                if (i_cfg_we) begin
                    n_report = 1'b0;
                end else if (w_accept) begin
                    n_report = 1'b1;
                    n_err    = 1'b0;
                    n_req    = i_req.req_type;
                    n_value  = i_req.value;
                    n_di     = i_req.digit_index;
                    n_dv     = i_req.digit_value;
                    n_sh     = i_req.shift_amount;
                    n_col    = i_req.colour;
                    n_all    = i_req.colour_all;
                end
            end
            ST_DISPATCH: begin
                n_ptr = '0;
                n_acc = '0;
                case (r_req)
                    REQ_SET_NUMBER: n_work = r_value;
                    REQ_INCREMENT:  n_work = (r_number < w_maxn) ? r_number + NUM_W'(1) : '0;
                    REQ_DECREMENT:  n_work = (r_number != '0) ? r_number - NUM_W'(1) : w_maxn;
                    REQ_SET_DIGIT:  n_err  = w_digit_bad;
                    REQ_SHIFT: begin
                        // Moving up walks from the top so sources are still unmodified.
                        n_down = w_shift_up;
                        n_ptr  = w_shift_up ? w_last_ptr : '0;
                    end
                    REQ_SET_COLOUR: n_err = !r_all && w_index_bad;
                    REQ_RENDER: begin
                        n_pix = '0;
                        n_led = '0;
                    end
                    default:        n_err = 1'b1;
                endcase
            end
            ST_SPLIT: begin
                n_work = NUM_W'(w_quot);
                n_ptr  = w_at_last ? '0 : r_ptr + CNT_W'(1);
            end
            ST_SUM_ADD: begin
                n_acc = r_acc + w_term;
                if (w_at_last) begin
                    n_number = r_acc + w_term;
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            ST_SHIFT_WRITE: begin
                if (w_shift_done) begin
                    n_ptr = '0;
                end else if (r_down) begin
                    n_ptr = r_ptr - CNT_W'(1);
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            ST_FILL: begin
                n_ptr = r_ptr + CNT_W'(1);
            end
            ST_PIXEL: begin
                if (i_res_ready) begin
                    n_pix = r_pix + PIX_W'(1);
                    if (r_led == LED_LAST) begin
                        n_led = '0;
                        n_ptr = r_ptr + CNT_W'(1);
                    end else begin
                        n_led = r_led + 4'd1;
                    end
                end
            end
            ST_SUM_READ, ST_SHIFT_READ, ST_STATUS, ST_FETCH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cfg    <= CNT_W'(MAX_DIGITS_DEF);
            r_number <= '0;
        end else begin
            r_state  <= n_state;
            r_number <= n_number;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_work   <= n_work;
        r_ptr    <= n_ptr;
        r_down   <= n_down;
        r_err    <= n_err;
        r_report <= n_report;
        r_led    <= n_led;
        r_pix    <= n_pix;
        r_req    <= n_req;
        r_value  <= n_value;
        r_di     <= n_di;
        r_dv     <= n_dv;
        r_sh     <= n_sh;
        r_col    <= n_col;
        r_all    <= n_all;
    end

endmodule

`default_nettype wire

FILE: design/decimal_digit_led_display_driver.sv
// One command at a time (N digits in use); set number, increment, decrement, set digit,
// shift, set colour and unknown commands each end in a status result.
// Render: one pixel per cycle within a pipe while the result path does not stall,
// and one extra digit-store read between pipes, for N*9 pixels.
// A num_digits write rebuilds the number with digit-store reads.
// Synchronous active-low reset: stores read as digits 0 and white, number 0, N=6.
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_led_display_driver #(
    parameter int MAX_DIGITS = dldd_pkg::MAX_DIGITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dldd_pkg::CNT_W-1:0] i_cfg_wdata,
    dldd_req_if.sink                   i_req,
    dldd_res_if.source                 o_res
);
    import dldd_pkg::*;

    localparam int AW = addr_w(MAX_DIGITS);

    logic             w_dig_we;
    logic [AW-1:0]    w_dig_waddr;
    logic [DIG_W-1:0] w_dig_wdata;
    logic [AW-1:0]    w_dig_raddr;
    logic [DIG_W-1:0] w_dig_rdata;
    logic             w_col_we;
    logic [AW-1:0]    w_col_waddr;
    logic [COL_W-1:0] w_col_wdata;
    logic [AW-1:0]    w_col_raddr;
    logic [COL_W-1:0] w_col_rdata;

    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;
    logic             r_out_valid;
    t_result          r_out;

    dldd_mem #(
        .WIDTH       (DIG_W),
        .DEPTH       (MAX_DIGITS),
        .RESET_VALUE ('0)
    ) u_digit_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_dig_we),
        .i_waddr (w_dig_waddr),
        .i_wdata (w_dig_wdata),
        .i_raddr (w_dig_raddr),
        .o_rdata (w_dig_rdata)
    );

    dldd_mem #(
        .WIDTH       (COL_W),
        .DEPTH       (MAX_DIGITS),
        .RESET_VALUE (WHITE_RGB)
    ) u_colour_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_col_we),
        .i_waddr (w_col_waddr),
        .i_wdata (w_col_wdata),
        .i_raddr (w_col_raddr),
        .o_rdata (w_col_rdata)
    );

    dldd_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_dig_we    (w_dig_we),
        .o_dig_waddr (w_dig_waddr),
        .o_dig_wdata (w_dig_wdata),
        .o_dig_raddr (w_dig_raddr),
        .i_dig_rdata (w_dig_rdata),
        .o_col_we    (w_col_we),
        .o_col_waddr (w_col_waddr),
        .o_col_wdata (w_col_wdata),
        .o_col_raddr (w_col_raddr),
        .i_col_rdata (w_col_rdata)
    );

    // Output register: takes a new result when empty or when its result transfers.
    assign w_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.is_pixel       = r_out.is_pixel;
    assign o_res.current_number = r_out.current_number;
    assign o_res.pixel_index    = r_out.pixel_index;
    assign o_res.pixel_colour   = r_out.pixel_colour;
    assign o_res.error_flag     = r_out.error_flag;
    assign o_res.last           = r_out.last;

endmodule

`default_nettype wire

FILE: design/dldd_checker.sv
// Port-level checks of the display driver, attached to the top level by bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dldd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_is_pixel,
    input logic [dldd_pkg::NUM_W-1:0] i_out_current_number,
    input logic [dldd_pkg::PIX_W-1:0] i_out_pixel_index,
    input logic [dldd_pkg::COL_W-1:0] i_out_pixel_colour,
    input logic                       i_out_error_flag,
    input logic                       i_out_last
);
    import dldd_pkg::*;

    // A stalled result keeps its payload.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_is_pixel) && $stable(i_out_current_number) && $stable(i_out_pixel_index) && $stable(i_out_pixel_colour) && $stable(i_out_error_flag) && $stable(i_out_last))

    // A status result is always the only result of its command.
    `ASSERT_IMPLY(a_status_last, i_clk, i_rst_n, i_out_valid && !i_out_is_pixel, i_out_last && (i_out_pixel_index == '0) && (i_out_pixel_colour == BLACK_RGB))

    // Pixels never carry an error and stay inside the LED chain.
    `ASSERT_IMPLY(a_pixel_clean, i_clk, i_rst_n, i_out_valid && i_out_is_pixel, !i_out_error_flag && (i_out_pixel_index < PIX_W'(MAX_DIGITS_DEF * LEDS_PER_DIGIT)))

    // The reported number is always a valid decimal value.
    `ASSERT_IMPLY(a_number_range, i_clk, i_rst_n, i_out_valid, i_out_current_number <= NUMBER_MAX)

    // A command is worked on alone: no second transfer right after one.
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind decimal_digit_led_display_driver dldd_checker u_dldd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_req.valid),
    .i_in_ready           (i_req.ready),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_out_is_pixel       (o_res.is_pixel),
    .i_out_current_number (o_res.current_number),
    .i_out_pixel_index    (o_res.pixel_index),
    .i_out_pixel_colour   (o_res.pixel_colour),
    .i_out_error_flag     (o_res.error_flag),
    .i_out_last           (o_res.last)
);

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench of the decimal digit LED display driver.
`timescale 1ns / 1ps

module tb_top;
    import dldd_pkg::*;

    // Command code outside the defined set.
    localparam logic [2:0] REQ_UNKNOWN = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int NUM_PHASES = 8;

    // One command as presented on the request channel.
    typedef struct packed {
        logic [2:0]             kind;
        logic [NUM_W-1:0]       value;
        logic [CNT_W-1:0]       idx;
        logic [DIG_W-1:0]       digit;
        logic signed [SH_W-1:0] shamt;
        logic [COL_W-1:0]       colour;
        logic                   colour_all;
    } t_command;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    dldd_req_if req_if();
    dldd_res_if res_if();

    decimal_digit_led_display_driver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // Mirror of the display state.
    logic [DIG_W-1:0] digit_mirror [MAX_DIGITS_DEF];
    logic [COL_W-1:0] colour_mirror [MAX_DIGITS_DEF];
    logic [NUM_W-1:0] number_mirror;
    logic [CNT_W-1:0] digits_setting;

    t_result  expected_results [$];
    t_command pending_cmds [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  fail_count;
    int  cmd_count;
    int  status_count;
    int  pixel_count;
    int  cycle_count;
    int  settings_used;
    logic req_taken;

    // Digits in use; out-of-range settings saturate to the legal range.
    function automatic int active_digits();
        int n;
        n = digits_setting;
        if (n < 1) n = 1;
        if (n > MAX_DIGITS_DEF) n = MAX_DIGITS_DEF;
        return n;
    endfunction

    function automatic int power_of_ten(input int e);
        int p;
        p = 1;
        for (int i = 0; i < e; i++) p = p * 10;
        return p;
    endfunction

    // Rebuild the binary number from the digits in use.
    function automatic void refresh_number();
        int sum;
        sum = 0;
        for (int i = 0; i < active_digits(); i++)
            sum += int'(digit_mirror[i]) * power_of_ten(i);
        number_mirror = sum[NUM_W-1:0];
    endfunction

    // Split a value into the digits in use, dropping the higher ones.
    function automatic void load_digits(input int v);
        for (int i = 0; i < active_digits(); i++) begin
            digit_mirror[i] = DIG_W'(v % 10);
            v = v / 10;
        end
        refresh_number();
    endfunction

    function automatic void clear_display();
        for (int i = 0; i < MAX_DIGITS_DEF; i++) begin
            digit_mirror[i] = '0;
            colour_mirror[i] = WHITE_RGB;
        end
        number_mirror = '0;
        digits_setting = 3'd6;
    endfunction

    // Update the mirror for one accepted command and queue the results it causes.
    function automatic void apply_command(input t_command c);
        int n;
        int top;
        int sh;
        int src;
        int k;
        int d;
        bit err;
        t_result r;
        logic [DIG_W-1:0] moved [MAX_DIGITS_DEF];
        n = active_digits();
        top = power_of_ten(n) - 1;
        err = 1'b0;
        case (c.kind)
            REQ_SET_NUMBER: begin
                load_digits(int'(c.value));
            end
            REQ_SET_DIGIT: begin
                if (c.digit > DIGIT_MAX || int'(c.idx) >= n) begin
                    err = 1'b1;
                end else begin
                    digit_mirror[c.idx] = c.digit;
                    refresh_number();
                end
            end
            REQ_INCREMENT: begin
                load_digits(int'(number_mirror) < top ? int'(number_mirror) + 1 : 0);
            end
            REQ_DECREMENT: begin
                load_digits(number_mirror > 0 ? int'(number_mirror) - 1 : top);
            end
            REQ_SHIFT: begin
                sh = int'($signed(c.shamt));
                for (int i = 0; i < n; i++) begin
                    src = i - sh;
                    moved[i] = (src >= 0 && src < n) ? digit_mirror[src] : '0;
                end
                for (int i = 0; i < n; i++) digit_mirror[i] = moved[i];
                refresh_number();
            end
            REQ_SET_COLOUR: begin
                if (c.colour_all) begin
                    for (int i = 0; i < n; i++) colour_mirror[i] = c.colour;
                end else if (int'(c.idx) < n) begin
                    colour_mirror[c.idx] = c.colour;
                end else begin
                    err = 1'b1;
                end
            end
            REQ_RENDER: begin
                // One pixel per LED, pipe 0 first.
                k = 0;
                for (int p = 0; p < n; p++) begin
                    d = digit_mirror[p];
                    for (int led = 0; led < LEDS_PER_DIGIT; led++) begin
                        r.is_pixel = 1'b1;
                        r.current_number = number_mirror;
                        r.pixel_index = PIX_W'(k);
                        if (d == 0 || led == d - 1) r.pixel_colour = colour_mirror[p];
                        else r.pixel_colour = BLACK_RGB;
                        r.error_flag = 1'b0;
                        r.last = (k == n * LEDS_PER_DIGIT - 1);
                        expected_results.push_back(r);
                        k++;
                    end
                end
                return;
            end
            default: begin
                err = 1'b1;
            end
        endcase
        r.is_pixel = 1'b0;
        r.current_number = number_mirror;
        r.pixel_index = '0;
        r.pixel_colour = '0;
        r.error_flag = err;
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic t_command make_cmd(input logic [2:0] kind, input int value,
                                          input int idx, input int digit, input int shamt,
                                          input int colour, input bit colour_all);
        t_command c;
        c.kind = kind;
        c.value = NUM_W'(value);
        c.idx = CNT_W'(idx);
        c.digit = DIG_W'(digit);
        c.shamt = SH_W'(shamt);
        c.colour = COL_W'(colour);
        c.colour_all = colour_all;
        return c;
    endfunction

    // Random command with random noise in the unused fields; the used fields are
    // mostly legal for n digits in use, with some out-of-range values mixed in.
    function automatic t_command random_command(input int n);
        t_command c;
        int pick;
        c.value = NUM_W'($urandom());
        c.idx = CNT_W'($urandom());
        c.digit = DIG_W'($urandom());
        c.shamt = SH_W'($urandom());
        c.colour = COL_W'($urandom());
        c.colour_all = 1'($urandom());
        pick = $urandom_range(99);
        if (pick < 14) c.kind = REQ_SET_NUMBER;
        else if (pick < 28) c.kind = REQ_SET_DIGIT;
        else if (pick < 40) c.kind = REQ_INCREMENT;
        else if (pick < 52) c.kind = REQ_DECREMENT;
        else if (pick < 66) c.kind = REQ_SHIFT;
        else if (pick < 80) c.kind = REQ_SET_COLOUR;
        else if (pick < 94) c.kind = REQ_RENDER;
        else c.kind = REQ_UNKNOWN;
        case ($urandom_range(3))
            0: c.value = NUM_W'($urandom_range(999999));
            1: c.value = NUM_W'($urandom_range(9));
            2: c.value = NUM_W'(999999 - $urandom_range(9));
            default: ;
        endcase
        if ($urandom_range(99) < 80) c.digit = DIG_W'($urandom_range(9));
        if ($urandom_range(99) < 80) c.idx = CNT_W'($urandom_range(n - 1));
        return c;
    endfunction

    // Wait until every command is taken and every result has come back.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0);
    endtask

    // Write the digit count while the block is idle.
    task automatic write_digit_count(input logic [CNT_W-1:0] count);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("FAIL decimal_digit_led_display_driver");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    // Request driver: presents the next queued command after a random gap.
    always @(negedge i_clk) begin
        t_command nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                req_if.valid <= 1'b1;
                req_if.req_type <= nxt.kind;
                req_if.value <= nxt.value;
                req_if.digit_index <= nxt.idx;
                req_if.digit_value <= nxt.digit;
                req_if.shift_amount <= nxt.shamt;
                req_if.colour <= nxt.colour;
                req_if.colour_all <= nxt.colour_all;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: tracks configuration writes and request transfers, and checks results.
    always @(posedge i_clk) begin
        t_command got_cmd;
        t_result want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (cfg_we) begin
                digits_setting = cfg_wdata;
                refresh_number();
            end
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                got_cmd.kind = req_if.req_type;
                got_cmd.value = req_if.value;
                got_cmd.idx = req_if.digit_index;
                got_cmd.digit = req_if.digit_value;
                got_cmd.shamt = req_if.shift_amount;
                got_cmd.colour = req_if.colour;
                got_cmd.colour_all = req_if.colour_all;
                apply_command(got_cmd);
                cmd_count++;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result transfer with no result expected.");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("is_pixel", want.is_pixel, res_if.is_pixel);
                    check_field("current_number", want.current_number, res_if.current_number);
                    check_field("pixel_index", want.pixel_index, res_if.pixel_index);
                    check_field("pixel_colour", want.pixel_colour, res_if.pixel_colour);
                    check_field("error_flag", want.error_flag, res_if.error_flag);
                    check_field("last", want.last, res_if.last);
                    if (want.is_pixel) pixel_count++;
                    else status_count++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        logic [CNT_W-1:0] count_plan [NUM_PHASES];
        count_plan = '{3'd6, 3'd0, 3'd1, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4};
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.value = '0;
        req_if.digit_index = '0;
        req_if.digit_value = '0;
        req_if.shift_amount = '0;
        req_if.colour = '0;
        req_if.colour_all = 1'b0;
        res_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        cmd_count = 0;
        status_count = 0;
        pixel_count = 0;
        cycle_count = 0;
        settings_used = 1;
        clear_display();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands with all six digits in use.
        pending_cmds.push_back(make_cmd(REQ_RENDER, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_NUMBER, 999999, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_INCREMENT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_DECREMENT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_NUMBER, 20'hFFFFF, 7, 15, -1, 24'hFFFFFF, 1));
        pending_cmds.push_back(make_cmd(REQ_SET_DIGIT, 0, 5, 9, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_DIGIT, 0, 0, 15, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_DIGIT, 0, 6, 3, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_DIGIT, 0, 7, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_NUMBER, 123456, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SHIFT, 0, 0, 0, 2, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SHIFT, 0, 0, 0, -3, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SHIFT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SHIFT, 0, 0, 0, 7, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_NUMBER, 654321, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SHIFT, 0, 0, 0, -8, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_NUMBER, 908070, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_COLOUR, 0, 7, 0, 0, 24'hFF00AA, 1));
        pending_cmds.push_back(make_cmd(REQ_SET_COLOUR, 0, 0, 0, 0, 24'h123456, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_COLOUR, 0, 1, 0, 0, 24'h000000, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_COLOUR, 0, 6, 0, 0, 24'h00FF00, 0));
        pending_cmds.push_back(make_cmd(REQ_SET_COLOUR, 0, 7, 0, 0, 24'h0000FF, 0));
        pending_cmds.push_back(make_cmd(REQ_UNKNOWN, 20'hFFFFF, 7, 15, -1, 24'hFFFFFF, 1));
        pending_cmds.push_back(make_cmd(REQ_RENDER, 0, 0, 0, 0, 0, 0));

        // Random phases, each after a digit-count write and under one of four flow-control mixes.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_digit_count(count_plan[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                pending_cmds.push_back(random_command(active_digits()));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d commands under %0d digit-count settings and four flow-control mixes.",
                 cmd_count, settings_used);
        $display("Checked %0d status results and %0d pixels.", status_count, pixel_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS decimal_digit_led_display_driver");
        end else begin
            $display("FAIL decimal_digit_led_display_driver");
        end
        $finish;
    end

endmodule
